/* rtl/ddlwc_pkg.sv */
// ----------------------------------------------------------------------------
// ddlwc_pkg: shared types and constants for the wheel command pipeline
// Field widths, register indexes, reset values and pipeline stage records.
// ----------------------------------------------------------------------------
package ddlwc_pkg;

   localparam int VEL_W      = 32;
   localparam int CFG_W      = 31;
   localparam int DIFF_W     = 33;
   localparam int MAG_W      = 32;
   localparam int SQ_W       = 66;
   localparam int ROOT_W     = 33;
   localparam int REM_W      = 36;
   localparam int LIM_W      = 46;
   localparam int SCL_REM_W  = 35;
   localparam int NUM_W      = 64;
   localparam int DIV_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SIDE1_W    = 3 * VEL_W + DIFF_W;
   localparam int SIDE2_W    = VEL_W;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_VEL_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANG_VEL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_ACC_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANG_ACC_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_TIME     = 3'd6;

   localparam logic [CFG_W-1:0] RST_BASE_WIDTH    = 31'd32768;
   localparam logic [CFG_W-1:0] RST_WHEEL_RADIUS  = 31'd10813;
   localparam logic [CFG_W-1:0] RST_LIN_VEL_LIMIT = 31'd65536;
   localparam logic [CFG_W-1:0] RST_ANG_VEL_LIMIT = 31'd65536;
   localparam logic [CFG_W-1:0] RST_LIN_ACC_LIMIT = 31'd65536;
   localparam logic [CFG_W-1:0] RST_ANG_ACC_LIMIT = 31'd65536;
   localparam logic [CFG_W-1:0] RST_STEP_TIME     = 31'd66;

   typedef struct packed {
      logic signed [VEL_W-1:0] want_vx;
      logic signed [VEL_W-1:0] want_vy;
      logic signed [VEL_W-1:0] want_wz;
      logic signed [VEL_W-1:0] now_vx;
      logic signed [VEL_W-1:0] now_vy;
      logic signed [VEL_W-1:0] now_wz;
   } req_data_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] right_wheel_rate;
      logic signed [VEL_W-1:0] left_wheel_rate;
   } rsp_data_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dw;
      logic signed [VEL_W-1:0]  nvx;
      logic signed [VEL_W-1:0]  nvy;
      logic signed [VEL_W-1:0]  nwz;
   } in_stage_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DIFF_W-1:0] vx;
      logic signed [DIFF_W-1:0] vy;
      logic signed [DIFF_W-1:0] wz;
   } mid_stage_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DIFF_W-1:0] vx;
      logic signed [NUM_W-1:0]  spin;
   } spin_stage_type;

   typedef struct packed {
      logic                    valid;
      logic signed [NUM_W-1:0] num_r;
      logic signed [NUM_W-1:0] num_l;
   } num_stage_type;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             ovf;
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] low;
      logic [DIV_W-1:0] q;
   } div_stage_type;

   typedef struct packed {
      logic              valid;
      logic              sx;
      logic              sy;
      logic [MAG_W-1:0]  ax;
      logic [MAG_W-1:0]  ay;
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   typedef struct packed {
      logic              valid;
      logic              sx;
      logic              sy;
      logic              clip;
      logic [MAG_W-1:0]  ax;
      logic [MAG_W-1:0]  ay;
      logic [ROOT_W-1:0] n;
      logic [ROOT_W-1:0] rx;
      logic [ROOT_W-1:0] ry;
      logic [MAG_W-1:0]  qx;
      logic [MAG_W-1:0]  qy;
   } scale_stage_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [MAG_W-1:0]  q;
   } scale_lane_type;

endpackage

/* rtl/ddlwc_vec_limit.sv */
// ----------------------------------------------------------------------------
// ddlwc_vec_limit: pipelined vector length limiter
// Rescales (x, y) so that floor(sqrt(x^2+y^2)) does not exceed lim. One
// root bit and one quotient bit step per stage; sideband rides along.
// ----------------------------------------------------------------------------
module ddlwc_vec_limit import ddlwc_pkg::*; #(
   parameter int SIDE_W = SIDE1_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic signed [DIFF_W-1:0] in_x,
   input  logic signed [DIFF_W-1:0] in_y,
   input  logic [LIM_W-1:0]         lim,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [DIFF_W-1:0] out_x,
   output logic signed [DIFF_W-1:0] out_y,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int SQRT_N = ROOT_W;
   localparam int SCL_N  = ROOT_W;
   localparam int LAT    = 2 + (SQRT_N + 1) + (SCL_N + 1) + 1;

   function automatic scale_lane_type scale_step(
      input logic [ROOT_W-1:0] rem,
      input logic [MAG_W-1:0]  v,
      input logic [ROOT_W-1:0] n,
      input logic              lbit,
      input logic [MAG_W-1:0]  q
   );
      logic [SCL_REM_W-1:0] t;
      logic [1:0]           c;
      scale_lane_type       r;
      t = {1'b0, rem, 1'b0} + (lbit ? SCL_REM_W'(v) : '0);
      c = 2'd0;
      if (t >= SCL_REM_W'(n)) begin
         t = t - SCL_REM_W'(n);
         c = 2'd1;
      end
      if (t >= SCL_REM_W'(n)) begin
         t = t - SCL_REM_W'(n);
         c = 2'd2;
      end
      r.rem = t[ROOT_W-1:0];
      r.q   = {q[MAG_W-2:0], 1'b0} + MAG_W'(c);
      return r;
   endfunction

   logic                   mag_v_ff, mag_sx_ff, mag_sy_ff;
   logic [MAG_W-1:0]       mag_ax_ff, mag_ay_ff;
   logic                   sq_v_ff, sq_sx_ff, sq_sy_ff;
   logic [MAG_W-1:0]       sq_ax_ff, sq_ay_ff;
   logic [2*MAG_W-1:0]     sq_a2_ff, sq_b2_ff;
   sqrt_stage_type         sqrt_ff [SQRT_N+1];
   scale_stage_type        scl_ff  [SCL_N+1];
   logic                   out_v_ff;
   logic signed [DIFF_W-1:0] out_x_ff, out_y_ff;
   logic [SIDE_W-1:0]      side_ff [LAT];
   scale_stage_type        scl0_in;
   logic [MAG_W-1:0]       mx, my;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_v_ff <= 1'b0;
         sq_v_ff  <= 1'b0;
      end else if (adv) begin
         mag_v_ff <= in_valid;
         sq_v_ff  <= mag_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_sx_ff <= in_x[DIFF_W-1];
         mag_sy_ff <= in_y[DIFF_W-1];
         mag_ax_ff <= in_x[DIFF_W-1] ? MAG_W'(-in_x) : MAG_W'(in_x);
         mag_ay_ff <= in_y[DIFF_W-1] ? MAG_W'(-in_y) : MAG_W'(in_y);
         sq_sx_ff  <= mag_sx_ff;
         sq_sy_ff  <= mag_sy_ff;
         sq_ax_ff  <= mag_ax_ff;
         sq_ay_ff  <= mag_ay_ff;
         sq_a2_ff  <= mag_ax_ff * mag_ax_ff;
         sq_b2_ff  <= mag_ay_ff * mag_ay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sqrt_ff[0].valid <= sq_v_ff;
         sqrt_ff[0].sx    <= sq_sx_ff;
         sqrt_ff[0].sy    <= sq_sy_ff;
         sqrt_ff[0].ax    <= sq_ax_ff;
         sqrt_ff[0].ay    <= sq_ay_ff;
         sqrt_ff[0].rad   <= SQ_W'(sq_a2_ff) + SQ_W'(sq_b2_ff);
         sqrt_ff[0].rem   <= '0;
         sqrt_ff[0].root  <= '0;
      end
   end

   for (genvar k = 1; k <= SQRT_N; k++) begin : g_sqrt
      logic [REM_W-1:0]  remn;
      logic [REM_W-1:0]  trial;
      sqrt_stage_type    nxt;
      always_comb begin
         remn  = {sqrt_ff[k-1].rem[REM_W-3:0], sqrt_ff[k-1].rad[SQ_W-1 -: 2]};
         trial = REM_W'({sqrt_ff[k-1].root, 2'b01});
         nxt   = sqrt_ff[k-1];
         nxt.rad = {sqrt_ff[k-1].rad[SQ_W-3:0], 2'b00};
         if (remn >= trial) begin
            nxt.rem  = remn - trial;
            nxt.root = {sqrt_ff[k-1].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt.rem  = remn;
            nxt.root = {sqrt_ff[k-1].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqrt_ff[k].valid <= 1'b0;
         end else if (adv) begin
            sqrt_ff[k] <= nxt;
         end
      end
   end

   always_comb begin
      scl0_in.valid = sqrt_ff[SQRT_N].valid;
      scl0_in.sx    = sqrt_ff[SQRT_N].sx;
      scl0_in.sy    = sqrt_ff[SQRT_N].sy;
      scl0_in.ax    = sqrt_ff[SQRT_N].ax;
      scl0_in.ay    = sqrt_ff[SQRT_N].ay;
      scl0_in.n     = sqrt_ff[SQRT_N].root;
      scl0_in.clip  = LIM_W'(sqrt_ff[SQRT_N].root) > lim;
      scl0_in.rx    = '0;
      scl0_in.ry    = '0;
      scl0_in.qx    = '0;
      scl0_in.qy    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff[0].valid <= 1'b0;
      end else if (adv) begin
         scl_ff[0] <= scl0_in;
      end
   end

   for (genvar k = 1; k <= SCL_N; k++) begin : g_scale
      scale_lane_type  lx, ly;
      scale_stage_type nxt;
      always_comb begin
         lx = scale_step(scl_ff[k-1].rx, scl_ff[k-1].ax, scl_ff[k-1].n,
                         lim[SCL_N-k], scl_ff[k-1].qx);
         ly = scale_step(scl_ff[k-1].ry, scl_ff[k-1].ay, scl_ff[k-1].n,
                         lim[SCL_N-k], scl_ff[k-1].qy);
         nxt    = scl_ff[k-1];
         nxt.rx = lx.rem;
         nxt.qx = lx.q;
         nxt.ry = ly.rem;
         nxt.qy = ly.q;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            scl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            scl_ff[k] <= nxt;
         end
      end
   end

   assign mx = scl_ff[SCL_N].clip ? scl_ff[SCL_N].qx : scl_ff[SCL_N].ax;
   assign my = scl_ff[SCL_N].clip ? scl_ff[SCL_N].qy : scl_ff[SCL_N].ay;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= scl_ff[SCL_N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= scl_ff[SCL_N].sx ? -$signed(DIFF_W'(mx)) : $signed(DIFF_W'(mx));
         out_y_ff <= scl_ff[SCL_N].sy ? -$signed(DIFF_W'(my)) : $signed(DIFF_W'(my));
         side_ff[0] <= in_side;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = out_v_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_side  = side_ff[LAT-1];

endmodule

/* rtl/diff_drive_limited_wheel_command.sv */
// ----------------------------------------------------------------------------
// diff_drive_limited_wheel_command: limited differential drive wheel rates
// Limits the velocity step and the velocity, then maps the base velocity
// to right and left wheel rates.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat holds desired and current base velocity (Q16.16).
//            Accepted when req_valid is high and req_stall is low.
//   rsp_*  : one beat with right and left wheel rate per request, in order.
//            Taken when rsp_valid is high and rsp_stall is low.
//   csr_*  : register writes, csr_ready is always high; write only while
//            the pipeline is empty. Unknown indexes are dropped.
//   Throughput is one beat per cycle while rsp_stall does not hold the
//   pipeline; the depth is set by the bit-per-stage square root and
//   rescale chains of both limiters and the 32-stage wheel divider.
//   Stall: while a result waits under rsp_stall the whole pipeline holds
//   and req_stall is raised; nothing is lost or repeated.
//   Reset: registers return to their defaults and the pipeline empties.
// ----------------------------------------------------------------------------
module diff_drive_limited_wheel_command import ddlwc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DIV_N = DIV_W;

   logic [CFG_W-1:0] base_width_ff, wheel_radius_ff, lin_vel_limit_ff;
   logic [CFG_W-1:0] ang_vel_limit_ff, lin_acc_limit_ff, ang_acc_limit_ff;
   logic [CFG_W-1:0] step_time_ff;
   logic [LIM_W-1:0] lmax_ff, amax_ff;
   logic [DIV_W-1:0] radius2_ff;
   logic [2*CFG_W-1:0] lprod, aprod;

   logic adv;
   in_stage_type   in_ff, in_in;
   mid_stage_type  mid_ff;
   spin_stage_type spin_ff;
   num_stage_type  num_ff;
   div_stage_type  div_ff [2][DIV_N+1];
   logic           rsp_valid_ff;
   rsp_data_type   rsp_ff;
   logic signed [VEL_W-1:0] lane_rate [2];

   logic [MAG_W-1:0]         dw_mag;
   logic [DIFF_W-1:0]        amax_trunc;
   logic signed [DIFF_W-1:0] dwc;
   logic [SIDE1_W-1:0]       side1_in, side1_out;
   logic                     l1_valid;
   logic signed [DIFF_W-1:0] l1_x, l1_y;
   logic signed [VEL_W-1:0]  s1_nvx, s1_nvy, s1_nwz;
   logic signed [DIFF_W-1:0] s1_dwc;

   logic [MAG_W-1:0]         wz_mag;
   logic [MAG_W-1:0]         wzc_mag;
   logic signed [VEL_W-1:0]  wzc;
   logic [SIDE2_W-1:0]       side2_out;
   logic                     l2_valid;
   logic signed [DIFF_W-1:0] l2_x, l2_y;
   logic signed [NUM_W-1:0]  vx_sh;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff    <= RST_BASE_WIDTH;
         wheel_radius_ff  <= RST_WHEEL_RADIUS;
         lin_vel_limit_ff <= RST_LIN_VEL_LIMIT;
         ang_vel_limit_ff <= RST_ANG_VEL_LIMIT;
         lin_acc_limit_ff <= RST_LIN_ACC_LIMIT;
         ang_acc_limit_ff <= RST_ANG_ACC_LIMIT;
         step_time_ff     <= RST_STEP_TIME;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BASE_WIDTH:    base_width_ff    <= csr_data[CFG_W-1:0];
            REG_WHEEL_RADIUS:  wheel_radius_ff  <= csr_data[CFG_W-1:0];
            REG_LIN_VEL_LIMIT: lin_vel_limit_ff <= csr_data[CFG_W-1:0];
            REG_ANG_VEL_LIMIT: ang_vel_limit_ff <= csr_data[CFG_W-1:0];
            REG_LIN_ACC_LIMIT: lin_acc_limit_ff <= csr_data[CFG_W-1:0];
            REG_ANG_ACC_LIMIT: ang_acc_limit_ff <= csr_data[CFG_W-1:0];
            REG_STEP_TIME:     step_time_ff     <= csr_data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   assign lprod = (2*CFG_W)'(lin_acc_limit_ff) * (2*CFG_W)'(step_time_ff);
   assign aprod = (2*CFG_W)'(ang_acc_limit_ff) * (2*CFG_W)'(step_time_ff);

   // step limits and divisor follow the registers in the next cycle
   always_ff @(posedge clock) begin
      lmax_ff    <= lprod[2*CFG_W-1:FRAC_W];
      amax_ff    <= aprod[2*CFG_W-1:FRAC_W];
      radius2_ff <= (wheel_radius_ff == '0) ? DIV_W'(2) : {wheel_radius_ff, 1'b0};
   end

   // ---- velocity change
   always_comb begin
      in_in.valid = req_valid;
      in_in.dx    = DIFF_W'(req_data.want_vx) - DIFF_W'(req_data.now_vx);
      in_in.dy    = DIFF_W'(req_data.want_vy) - DIFF_W'(req_data.now_vy);
      in_in.dw    = DIFF_W'(req_data.want_wz) - DIFF_W'(req_data.now_wz);
      in_in.nvx   = req_data.now_vx;
      in_in.nvy   = req_data.now_vy;
      in_in.nwz   = req_data.now_wz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (adv) begin
         in_ff <= in_in;
      end
   end

   assign dw_mag     = in_ff.dw[DIFF_W-1] ? MAG_W'(-in_ff.dw) : MAG_W'(in_ff.dw);
   assign amax_trunc = amax_ff[DIFF_W-1:0];

   always_comb begin
      if (LIM_W'(dw_mag) > amax_ff) begin
         dwc = in_ff.dw[DIFF_W-1] ? -$signed(amax_trunc) : $signed(amax_trunc);
      end else begin
         dwc = in_ff.dw;
      end
   end

   assign side1_in = {in_ff.nvx, in_ff.nvy, in_ff.nwz, dwc};

   ddlwc_vec_limit #(
      .SIDE_W(SIDE1_W)
   ) u_step_limit (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (in_ff.valid),
      .in_x     (in_ff.dx),
      .in_y     (in_ff.dy),
      .lim      (lmax_ff),
      .in_side  (side1_in),
      .out_valid(l1_valid),
      .out_x    (l1_x),
      .out_y    (l1_y),
      .out_side (side1_out)
   );

   assign {s1_nvx, s1_nvy, s1_nwz, s1_dwc} = side1_out;

   // ---- new velocity
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else if (adv) begin
         mid_ff.valid <= l1_valid;
         mid_ff.vx    <= DIFF_W'(s1_nvx) + l1_x;
         mid_ff.vy    <= DIFF_W'(s1_nvy) + l1_y;
         mid_ff.wz    <= DIFF_W'(s1_nwz) + s1_dwc;
      end
   end

   assign wz_mag = mid_ff.wz[DIFF_W-1] ? MAG_W'(-mid_ff.wz) : MAG_W'(mid_ff.wz);

   always_comb begin
      if (wz_mag > MAG_W'(ang_vel_limit_ff)) begin
         wzc = mid_ff.wz[DIFF_W-1] ? -$signed(VEL_W'(ang_vel_limit_ff))
                                   : $signed(VEL_W'(ang_vel_limit_ff));
      end else begin
         wzc = VEL_W'(mid_ff.wz);
      end
   end

   assign wzc_mag = wzc[VEL_W-1] ? MAG_W'(-wzc) : MAG_W'(wzc);

   ddlwc_vec_limit #(
      .SIDE_W(SIDE2_W)
   ) u_vel_limit (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (mid_ff.valid),
      .in_x     (mid_ff.vx),
      .in_y     (mid_ff.vy),
      .lim      (LIM_W'(lin_vel_limit_ff)),
      .in_side  (wzc),
      .out_valid(l2_valid),
      .out_x    (l2_x),
      .out_y    (l2_y),
      .out_side (side2_out)
   );

   // ---- wheel numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         spin_ff.valid <= 1'b0;
      end else if (adv) begin
         spin_ff.valid <= l2_valid;
         spin_ff.vx    <= l2_x;
         spin_ff.spin  <= $signed(side2_out) * $signed({1'b0, base_width_ff});
      end
   end

   assign vx_sh = $signed({{(NUM_W-DIFF_W-17){spin_ff.vx[DIFF_W-1]}}, spin_ff.vx, 17'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff.valid <= 1'b0;
      end else if (adv) begin
         num_ff.valid <= spin_ff.valid;
         num_ff.num_r <= vx_sh + spin_ff.spin;
         num_ff.num_l <= vx_sh - spin_ff.spin;
      end
   end

   // ---- divide by twice the radius (by 2 for a zero radius), truncating toward zero and saturating
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        num_mag;
      logic signed [VEL_W-1:0] rate;

      assign num     = (l == 0) ? num_ff.num_r : num_ff.num_l;
      assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[l][0].valid <= 1'b0;
         end else if (adv) begin
            div_ff[l][0].valid <= num_ff.valid;
            div_ff[l][0].neg   <= num[NUM_W-1];
            div_ff[l][0].ovf   <= 1'b0;
            div_ff[l][0].rem   <= num_mag[NUM_W-1:DIV_W];
            div_ff[l][0].low   <= num_mag[DIV_W-1:0];
            div_ff[l][0].q     <= '0;
         end
      end

      for (genvar k = 1; k <= DIV_N; k++) begin : g_div
         logic [DIV_W:0] r2;
         div_stage_type  nxt;
         always_comb begin
            r2      = {div_ff[l][k-1].rem, div_ff[l][k-1].low[DIV_W-1]};
            nxt     = div_ff[l][k-1];
            nxt.low = {div_ff[l][k-1].low[DIV_W-2:0], 1'b0};
            if (k == 1) begin
               nxt.ovf = div_ff[l][k-1].rem >= radius2_ff;
            end
            if (r2 >= {1'b0, radius2_ff}) begin
               nxt.rem = DIV_W'(r2 - {1'b0, radius2_ff});
               nxt.q   = {div_ff[l][k-1].q[DIV_W-2:0], 1'b1};
            end else begin
               nxt.rem = r2[DIV_W-1:0];
               nxt.q   = {div_ff[l][k-1].q[DIV_W-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               div_ff[l][k].valid <= 1'b0;
            end else if (adv) begin
               div_ff[l][k] <= nxt;
            end
         end
      end

      always_comb begin
         if (div_ff[l][DIV_N].neg) begin
            if (div_ff[l][DIV_N].ovf ||
                div_ff[l][DIV_N].q > {1'b1, {(DIV_W-1){1'b0}}}) begin
               rate = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
               rate = -$signed(div_ff[l][DIV_N].q);
            end
         end else begin
            if (div_ff[l][DIV_N].ovf || div_ff[l][DIV_N].q[DIV_W-1]) begin
               rate = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
               rate = $signed(div_ff[l][DIV_N].q);
            end
         end
      end

      assign lane_rate[l] = rate;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.right_wheel_rate <= lane_rate[0];
         rsp_ff.left_wheel_rate  <= lane_rate[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_ff[0][DIV_N].valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_wz_limited: assert property (@(posedge clock) disable iff (reset)
      mid_ff.valid |-> (wzc_mag <= MAG_W'(ang_vel_limit_ff)))
      else $error("yaw rate above limit after clamp");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && mid_ff.valid) |=> $stable(mid_ff))
      else $error("pipeline stage moved during stall");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (div_ff[0][DIV_N].valid && !div_ff[0][DIV_N].ovf)
         |-> (div_ff[0][DIV_N].rem < radius2_ff))
      else $error("divider remainder not below divisor");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(adv))
      else $error("result appeared without pipeline advance");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: wheel command pipeline testbench
// Drives base velocity commands through the pipeline under random gaps and
// stalls, predicts the limited wheel rates per command, and compares every
// result beat in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
   import ddlwc_pkg::*;

   localparam int LATENCY   = 180;
   localparam int WDOG_MAX  = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_data_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers
   logic [CFG_W-1:0] cfg_regs [0:6];

   rsp_data_type wheel_q [$];
   int           fail_cnt = 0;
   int           idle_cycles = 0;
   int           rsp_wait = 0;
   bit           hold_rsp = 1'b0;
   bit           rand_rsp_idle = 1'b1;

   diff_drive_limited_wheel_command DUT (.*);

   always #5 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic logic [127:0] isqrt(logic [127:0] v);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 126;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void clip_vec(inout longint x, inout longint y,
                                    input longint unsigned lim);
      longint unsigned ux, uy, n;
      logic [127:0] sq;
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      sq = 128'(ux) * ux + 128'(uy) * uy;
      n  = 64'(isqrt(sq));
      if (n > lim) begin
         ux = 64'((128'(ux) * lim) / n);
         uy = 64'((128'(uy) * lim) / n);
         x = x < 0 ? -longint'(ux) : longint'(ux);
         y = y < 0 ? -longint'(uy) : longint'(uy);
      end
   endfunction

   function automatic longint clamp_yaw(longint w, longint unsigned lim);
      longint unsigned m;
      m = w < 0 ? -w : w;
      if (m > lim) return w < 0 ? -longint'(lim) : longint'(lim);
      return w;
   endfunction

   function automatic logic [31:0] wheel_sat(logic signed [127:0] num, longint unsigned rad);
      logic signed [127:0] q;
      q = num / $signed({64'd0, 64'(2 * rad)});
      if (q > 128'sd2147483647) q = 128'sd2147483647;
      if (q < -128'sd2147483648) q = -128'sd2147483648;
      return q[31:0];
   endfunction

   function automatic rsp_data_type wheel_rates(req_data_type c);
      longint unsigned lmax, amax, rad;
      longint dx, dy, dw, vx, vy, wz;
      logic signed [127:0] spin, base;
      rsp_data_type r;
      lmax = (64'(cfg_regs[REG_LIN_ACC_LIMIT]) * cfg_regs[REG_STEP_TIME]) >> 16;
      amax = (64'(cfg_regs[REG_ANG_ACC_LIMIT]) * cfg_regs[REG_STEP_TIME]) >> 16;
      rad  = cfg_regs[REG_WHEEL_RADIUS] == 0 ? 1 : cfg_regs[REG_WHEEL_RADIUS];
      dx = longint'(c.want_vx) - longint'(c.now_vx);
      dy = longint'(c.want_vy) - longint'(c.now_vy);
      dw = longint'(c.want_wz) - longint'(c.now_wz);
      clip_vec(dx, dy, lmax);
      dw = clamp_yaw(dw, amax);
      vx = longint'(c.now_vx) + dx;
      vy = longint'(c.now_vy) + dy;
      wz = longint'(c.now_wz) + dw;
      clip_vec(vx, vy, 64'(cfg_regs[REG_LIN_VEL_LIMIT]));
      wz = clamp_yaw(wz, 64'(cfg_regs[REG_ANG_VEL_LIMIT]));
      spin = 128'(wz) * $signed({97'd0, cfg_regs[REG_BASE_WIDTH]});
      base = 128'(vx) * 128'sd131072;
      r.right_wheel_rate = wheel_sat(base + spin, rad);
      r.left_wheel_rate  = wheel_sat(base - spin, rad);
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report(string what, logic [31:0] got, logic [31:0] exp);
      $display("ERROR %s: got %h expected %h at %0t", what, got, exp, $time);
      fail_cnt++;
   endtask

   always @(posedge clock) begin
      rsp_data_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wheel_q.size() == 0) begin
            report("unexpected beat", rsp_data.right_wheel_rate, 0);
         end else begin
            e = wheel_q.pop_front();
            if (rsp_data.right_wheel_rate !== e.right_wheel_rate)
               report("right_wheel_rate", rsp_data.right_wheel_rate, e.right_wheel_rate);
            if (rsp_data.left_wheel_rate !== e.left_wheel_rate)
               report("left_wheel_rate", rsp_data.left_wheel_rate, e.left_wheel_rate);
         end
      end
   end

   // receiver stall: after each taken beat stall at random while rand_rsp_idle is set, or hold off entirely
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait = rand_rsp_idle ? $urandom_range(0, 7) : 0;
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_wait > 1) begin
         rsp_wait = rsp_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_wait = 0;
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   bit gaps_on = 1'b1;

   task automatic send_cmd(req_data_type c);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      wheel_q.push_back(wheel_rates(c));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (wheel_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= REG_STEP_TIME) cfg_regs[idx] = val[CFG_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_vel(int kind);
      case (kind)
         0: return $urandom();
         1: return $urandom_range(0, 262143) - 131072;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom_range(0, 16777215) - 8388608;
      endcase
   endfunction

   function automatic req_data_type rand_cmd();
      req_data_type c;
      int k;
      k = $urandom_range(0, 3);
      c.want_vx = rand_vel(k);
      c.want_vy = rand_vel(k);
      c.want_wz = rand_vel(k);
      c.now_vx  = rand_vel($urandom_range(0, 3));
      c.now_vy  = rand_vel($urandom_range(0, 3));
      c.now_wz  = rand_vel($urandom_range(0, 3));
      return c;
   endfunction

   function automatic req_data_type mk(logic [31:0] a, b, c, d, e, f);
      req_data_type r;
      r = {a, b, c, d, e, f};
      return r;
   endfunction

   task automatic test_directed();
      send_cmd(mk(0, 0, 0, 0, 0, 0));
      send_cmd(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h80000000, 32'h80000000, 32'h80000000));
      send_cmd(mk(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send_cmd(mk(32'h00010000, 0, 32'h00010000, 0, 0, 0));
      send_cmd(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      send_cmd(mk(32'h00008000, 32'h00008000, 32'hFFFF0000,
                  32'h00007000, 32'h00007000, 32'hFFFF1000));
      send_cmd(mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                  32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
      drain();
      // limits wide open, small radius: saturation
      write_reg(REG_LIN_VEL_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_ANG_VEL_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_LIN_ACC_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_ANG_ACC_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_STEP_TIME,     32'h7FFFFFFF);
      write_reg(REG_WHEEL_RADIUS,  32'h00000001);
      write_reg(REG_BASE_WIDTH,    32'h7FFFFFFF);
      write_reg(3'd7, 32'h12345678);
      send_cmd(mk(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0, 0, 0));
      send_cmd(mk(32'h80000000, 0, 32'h80000000, 0, 0, 0));
      send_cmd(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h7FFFFFFF));
      send_cmd(mk(1, 1, 1, 0, 0, 0));
      drain();
      // zero radius, zero step time, zero acceleration and velocity limits, high bits ignored
      write_reg(REG_WHEEL_RADIUS, 32'h80000000);
      write_reg(REG_STEP_TIME, 0);
      send_cmd(mk(32'h00100000, 0, 32'h00100000, 32'h00020000, 0, 32'hFFFE0000));
      drain();
      write_reg(REG_STEP_TIME, 32'hFFFFFFFF);
      write_reg(REG_LIN_ACC_LIMIT, 0);
      write_reg(REG_ANG_ACC_LIMIT, 0);
      send_cmd(mk(32'h00100000, 0, 32'h00100000, 32'h00020000, 0, 32'hFFFE0000));
      drain();
      write_reg(REG_LIN_ACC_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_ANG_ACC_LIMIT, 32'h7FFFFFFF);
      write_reg(REG_LIN_VEL_LIMIT, 0);
      write_reg(REG_ANG_VEL_LIMIT, 0);
      send_cmd(mk(32'h00100000, 32'h00300000, 32'h00100000, 0, 0, 0));
      send_cmd(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
      drain();
   endtask

   task automatic random_phase(int count, logic [31:0] regs [0:6]);
      for (int i = 0; i <= 6; i++) write_reg(i[CSR_IDX_W-1:0], regs[i]);
      for (int i = 0; i < count; i++) send_cmd(rand_cmd());
      drain();
   endtask

   task automatic test_random();
      logic [31:0] r [0:6];
      for (int p = 0; p < 10; p++) begin
         r[REG_BASE_WIDTH]    = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 131072);
         r[REG_WHEEL_RADIUS]  = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 65536);
         r[REG_LIN_VEL_LIMIT] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 20);
         r[REG_ANG_VEL_LIMIT] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 20);
         r[REG_LIN_ACC_LIMIT] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 22);
         r[REG_ANG_ACC_LIMIT] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 22);
         r[REG_STEP_TIME]     = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 16);
         if (p == 0) r = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
         if (p == 1) r = '{1, 1, 0, 0, 0, 0, 1};
         gaps_on = (p % 3 != 2);
         rand_rsp_idle = (p % 3 != 2);
         random_phase(110, r);
      end
      rand_rsp_idle = 1'b1;
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            gaps_on = 1'b0;
            for (int i = 0; i < 250; i++) send_cmd(rand_cmd());
            gaps_on = 1'b1;
            end_burst();
         end
      join
      drain();
   endtask

   initial begin
      for (int i = 0; i <= 6; i++) cfg_regs[i] = '0;
      cfg_regs[REG_BASE_WIDTH]    = RST_BASE_WIDTH;
      cfg_regs[REG_WHEEL_RADIUS]  = RST_WHEEL_RADIUS;
      cfg_regs[REG_LIN_VEL_LIMIT] = RST_LIN_VEL_LIMIT;
      cfg_regs[REG_ANG_VEL_LIMIT] = RST_ANG_VEL_LIMIT;
      cfg_regs[REG_LIN_ACC_LIMIT] = RST_LIN_ACC_LIMIT;
      cfg_regs[REG_ANG_ACC_LIMIT] = RST_ANG_ACC_LIMIT;
      cfg_regs[REG_STEP_TIME]     = RST_STEP_TIME;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_cnt == 0 && wheel_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
